FILE: rtl/core/gsplat_pkg.sv
// gsplat_pkg: shared types, register and status codes, and the exp2 table
// for the gaussian grid splat core. No dependencies.
package gsplat_pkg;

  // grid size defaults
  localparam int DEF_GRID_COLS = 256;
  localparam int DEF_GRID_ROWS = 256;

  localparam int CELL_W = 48;

  // configuration register indexes
  localparam logic [2:0] CFG_MASS_LOW   = 3'd0;
  localparam logic [2:0] CFG_MASS_HIGH  = 3'd1;
  localparam logic [2:0] CFG_TIME_LOW   = 3'd2;
  localparam logic [2:0] CFG_TIME_HIGH  = 3'd3;
  localparam logic [2:0] CFG_SIGMA_REF  = 3'd4;
  localparam logic [2:0] CFG_MASS_REF   = 3'd5;
  localparam logic [2:0] CFG_TIME_SIGMA = 3'd6;
  localparam logic [2:0] CFG_INSTRUMENT = 3'd7;

  // configuration reset values
  localparam logic [31:0] RST_MASS_LOW   = 32'd0;
  localparam logic [31:0] RST_MASS_HIGH  = 32'd131072000;
  localparam logic [31:0] RST_TIME_LOW   = 32'd0;
  localparam logic [31:0] RST_TIME_HIGH  = 32'd65536000;
  localparam logic [31:0] RST_SIGMA_REF  = 32'd655;
  localparam logic [31:0] RST_MASS_REF   = 32'd13107200;
  localparam logic [31:0] RST_TIME_SIGMA = 32'd655360;

  // instrument codes
  localparam logic [1:0] INST_ORBITRAP = 2'd0;
  localparam logic [1:0] INST_FTICR    = 2'd1;
  localparam logic [1:0] INST_TOF      = 2'd2;
  localparam logic [1:0] INST_QUAD     = 2'd3;

  // transaction kinds
  localparam logic KIND_SPLAT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_SPLAT_OK  = 2'd0;
  localparam logic [1:0] ST_SPLAT_REJ = 2'd1;
  localparam logic [1:0] ST_READ_OK   = 2'd2;
  localparam logic [1:0] ST_READ_OOR  = 2'd3;

  // divider step counts (quotient bits produced)
  localparam logic [6:0] DIV_STEPS_FULL  = 7'd64;
  localparam logic [6:0] DIV_STEPS_RATIO = 7'd48;
  localparam logic [6:0] DIV_STEPS_CLIP  = 7'd40;
  localparam logic [6:0] DIV_STEPS_SPAN  = 7'd32;
  localparam logic [6:0] DIV_STEPS_DIST  = 7'd12;

  // log2(e)/2 in Q.16
  localparam logic [15:0] HALF_LOG2E = 16'd47274;
  localparam logic [11:0] DIST_MAX   = 12'd4095;

  typedef struct packed {
    logic        kind;
    logic [31:0] point_mass;
    logic [31:0] point_time;
    logic [31:0] intensity;
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CELL_W-1:0] cell_value;
  } out_t;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
    logic [6:0]  steps;
  } div_req_t;

  // 2^(-n/16) in Q.16, n = 0..16
  function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/gaussian_grid_splat_core.sv
// gaussian_grid_splat_core: gaussian splatting into a grid of saturating cells.
// Read transaction: the cell is read through the registered grid port. Splat: set-up
// (sigma scaling, deltas and up to four clip divisions on the serial divider), then
// one read-modify-write per covered cell, bound by the 12-step divider.
// Reset: synchronous, active low; the grid is zeroed by a sweep over all
// GRID_COLS*GRID_ROWS cells, during which no transaction is taken.
module gaussian_grid_splat_core #(
  parameter int GRID_COLS = gsplat_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = gsplat_pkg::DEF_GRID_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gsplat_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gsplat_pkg::out_t  out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import gsplat_pkg::*;

  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int DEPTH  = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE, S_RADDR, S_RWAIT, S_RDATA,
    S_SIG, S_TOF, S_TOFQ, S_RQ, S_SQR, S_ISQ, S_SWAIT, S_SMUL, S_SFIN,
    S_CHK, S_DM, S_DT, S_BOX, S_CLIP, S_CLIPR, S_LOOP,
    S_ROW, S_ROWB, S_ROWQ, S_ROWSQ, S_COL, S_COLB, S_COLQ,
    S_Q, S_T, S_W1, S_W2, S_ADD, S_WR, S_DWAIT, S_DONE
  } state_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // configuration registers
  logic [31:0] mass_low_r, mass_high_r, time_low_r, time_high_r;
  logic [31:0] sigma_ref_r, mass_ref_r, time_sigma_r;
  logic [1:0]  instrument_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_low_r   <= RST_MASS_LOW;
      mass_high_r  <= RST_MASS_HIGH;
      time_low_r   <= RST_TIME_LOW;
      time_high_r  <= RST_TIME_HIGH;
      sigma_ref_r  <= RST_SIGMA_REF;
      mass_ref_r   <= RST_MASS_REF;
      time_sigma_r <= RST_TIME_SIGMA;
      instrument_r <= INST_ORBITRAP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASS_LOW:   mass_low_r   <= cfg_data;
        CFG_MASS_HIGH:  mass_high_r  <= cfg_data;
        CFG_TIME_LOW:   time_low_r   <= cfg_data;
        CFG_TIME_HIGH:  time_high_r  <= cfg_data;
        CFG_SIGMA_REF:  sigma_ref_r  <= cfg_data;
        CFG_MASS_REF:   mass_ref_r   <= cfg_data;
        CFG_TIME_SIGMA: time_sigma_r <= cfg_data;
        CFG_INSTRUMENT: instrument_r <= cfg_data[1:0];
        default:        ;
      endcase
    end
  end

  // sequencer state and datapath registers
  state_t state_r, ret_r;
  logic              kind_r;
  logic [31:0]       pm_r, pt_r, inten_r;
  logic [7:0]        col_r, row_r;
  logic [31:0]       sm_r, dm_r, dt_r, ratio_r;
  logic [63:0]       mul_r;
  logic [1:0]        clip_sel_r;
  logic [COL_W-1:0]  i0_r, i1_r, i_r;
  logic [ROW_W-1:0]  j0_r, j1_r, j_r;
  logic [ADDR_W-1:0] rowbase_r;
  logic [44:0]       coord_r;
  logic [11:0]       a_r, b_r;
  logic [23:0]       b2_r;
  logic [24:0]       q_r, t_r;
  logic [16:0]       base_r;
  logic [23:0]       prod_r;
  logic [8:0]        k_r;
  logic [15:0]       w_r;
  logic [47:0]       add_r;
  logic [1:0]        status_r;
  logic [47:0]       cell_r;
  logic              out_valid_r;
  out_t              out_data_r;
  div_req_t          div_req_r;
  logic              sq_start_r;
  logic [47:0]       sq_val_r;
  logic              mem_rd_r, mem_wr_r;
  logic [ADDR_W-1:0] mem_addr_r;
  logic [47:0]       mem_wdata_r;

  logic        div_done;
  logic [63:0] div_quo;
  logic        sq_done;
  logic [23:0] sq_root;
  logic [47:0] mem_rdata;
  logic        grid_busy;

  // shared units
  gsplat_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req_r),
    .done (div_done),
    .quo  (div_quo)
  );

  gsplat_isqrt u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start_r),
    .value(sq_val_r),
    .done (sq_done),
    .root (sq_root)
  );

  gsplat_grid #(.DEPTH(DEPTH)) u_grid (
    .clk  (clk),
    .rst_n(rst_n),
    .rd_en(mem_rd_r),
    .wr_en(mem_wr_r),
    .addr (mem_addr_r),
    .wdata(mem_wdata_r),
    .rdata(mem_rdata),
    .busy (grid_busy)
  );

  // +-2 sigma box and bounds check
  logic signed [34:0] lo_m, hi_m, lo_t, hi_t;
  logic signed [34:0] mlow_s, mhigh_s, tlow_s, thigh_s;
  logic               outside;

  always_comb begin
    lo_m    = $signed({3'b0, pm_r}) - $signed({2'b0, sm_r, 1'b0});
    hi_m    = $signed({3'b0, pm_r}) + $signed({2'b0, sm_r, 1'b0});
    lo_t    = $signed({3'b0, pt_r}) - $signed({2'b0, time_sigma_r, 1'b0});
    hi_t    = $signed({3'b0, pt_r}) + $signed({2'b0, time_sigma_r, 1'b0});
    mlow_s  = $signed({3'b0, mass_low_r});
    mhigh_s = $signed({3'b0, mass_high_r});
    tlow_s  = $signed({3'b0, time_low_r});
    thigh_s = $signed({3'b0, time_high_r});
    outside = (hi_t < tlow_s) || (hi_m < mlow_s) || (lo_t > thigh_s) || (lo_m > mhigh_s);
  end

  // index clipping of one box edge
  logic signed [34:0] clip_v, clip_low, clip_diff;
  logic [31:0]        clip_dlt;
  logic [63:0]        clip_lim, clip_val;
  logic               clip_below;

  always_comb begin
    case (clip_sel_r)
      2'd0: begin
        clip_v = lo_m; clip_low = mlow_s; clip_dlt = dm_r;
        clip_lim = 64'(GRID_COLS - 1);
      end
      2'd1: begin
        clip_v = hi_m; clip_low = mlow_s; clip_dlt = dm_r;
        clip_lim = 64'(GRID_COLS - 1);
      end
      2'd2: begin
        clip_v = lo_t; clip_low = tlow_s; clip_dlt = dt_r;
        clip_lim = 64'(GRID_ROWS - 1);
      end
      default: begin
        clip_v = hi_t; clip_low = tlow_s; clip_dlt = dt_r;
        clip_lim = 64'(GRID_ROWS - 1);
      end
    endcase
    clip_below = clip_v < clip_low;
    clip_diff  = clip_v - clip_low;
    if (clip_below) begin
      clip_val = '0;
    end else begin
      clip_val = (div_quo > clip_lim) ? clip_lim : div_quo;
    end
  end

  // distance of the current coordinate from the point, in sigma units
  logic [31:0]        dist_p, dist_s;
  logic signed [46:0] dist_d;
  logic [45:0]        dist_ad;
  logic               dist_big;
  logic [63:0]        dist_num;

  always_comb begin
    dist_p   = (state_r == S_ROWB) ? pt_r : pm_r;
    dist_s   = (state_r == S_ROWB) ? time_sigma_r : sm_r;
    dist_d   = $signed({2'b0, coord_r}) - $signed({15'b0, dist_p});
    dist_ad  = dist_d[46] ? 46'(-dist_d) : dist_d[45:0];
    dist_big = dist_ad >= {10'b0, dist_s, 4'b0};
    dist_num = {10'b0, dist_ad, 8'b0};
  end

  // weight shift and cap, saturating cell sum
  logic [16:0] w_lin, w_sh;
  logic [15:0] w_val;
  logic [48:0] cell_sum;
  logic [47:0] cell_new;
  logic        can_load;

  always_comb begin
    w_lin = base_r - {5'b0, prod_r[23:12]};
    w_sh  = w_lin >> k_r[4:0];
    if (k_r > 9'd16) begin
      w_val = '0;
    end else begin
      w_val = (w_sh > 17'd65535) ? 16'hFFFF : w_sh[15:0];
    end
    cell_sum = {1'b0, mem_rdata} + {1'b0, add_r};
    cell_new = cell_sum[48] ? '1 : cell_sum[47:0];
    can_load = !out_valid_r || !out_stall;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      div_req_r   <= '0;
      sq_start_r  <= 1'b0;
      mem_rd_r    <= 1'b0;
      mem_wr_r    <= 1'b0;
      clip_sel_r  <= '0;
    end else begin
      div_req_r.start <= 1'b0;
      sq_start_r      <= 1'b0;
      mem_rd_r        <= 1'b0;
      mem_wr_r        <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            kind_r  <= in_data.kind;
            pm_r    <= in_data.point_mass;
            pt_r    <= in_data.point_time;
            inten_r <= in_data.intensity;
            col_r   <= in_data.cell_col;
            row_r   <= in_data.cell_row;
            cell_r  <= '0;
            state_r <= (in_data.kind == KIND_READ) ? S_RADDR : S_SIG;
          end
        end

        // read transaction
        S_RADDR: begin
          if ({24'b0, col_r} >= 32'(GRID_COLS) || {24'b0, row_r} >= 32'(GRID_ROWS)) begin
            status_r <= ST_READ_OOR;
            state_r  <= S_DONE;
          end else begin
            mem_rd_r   <= 1'b1;
            mem_addr_r <= ADDR_W'(col_r) + ADDR_W'(row_r * GRID_COLS);
            state_r    <= S_RWAIT;
          end
        end
        S_RWAIT: state_r <= S_RDATA;
        S_RDATA: begin
          cell_r   <= mem_rdata;
          status_r <= ST_READ_OK;
          state_r  <= S_DONE;
        end

        // mass sigma by instrument
        S_SIG: begin
          if (instrument_r == INST_QUAD) begin
            sm_r    <= sigma_ref_r;
            state_r <= S_CHK;
          end else if (mass_ref_r == '0) begin
            sm_r    <= '0;
            state_r <= S_CHK;
          end else if (instrument_r == INST_TOF) begin
            mul_r   <= sigma_ref_r * pm_r;
            state_r <= S_TOF;
          end else begin
            div_req_r <= '{start: 1'b1, num: {16'b0, pm_r, 16'b0}, den: mass_ref_r,
                           steps: DIV_STEPS_RATIO};
            ret_r     <= S_RQ;
            state_r   <= S_DWAIT;
          end
        end
        S_TOF: begin
          div_req_r <= '{start: 1'b1, num: mul_r, den: mass_ref_r, steps: DIV_STEPS_FULL};
          ret_r     <= S_TOFQ;
          state_r   <= S_DWAIT;
        end
        S_TOFQ: begin
          sm_r    <= sat32(div_quo);
          state_r <= S_CHK;
        end
        S_RQ: begin
          ratio_r <= sat32(div_quo);
          state_r <= (instrument_r == INST_FTICR) ? S_SQR : S_ISQ;
        end
        S_SQR: begin
          mul_r   <= ratio_r * ratio_r;
          state_r <= S_SMUL;
        end
        S_ISQ: begin
          sq_start_r <= 1'b1;
          sq_val_r   <= {ratio_r, 16'b0};
          state_r    <= S_SWAIT;
        end
        S_SWAIT: begin
          if (sq_done) begin
            mul_r   <= ratio_r * {8'b0, sq_root};
            state_r <= S_SMUL;
          end
        end
        S_SMUL: begin
          mul_r   <= sigma_ref_r * sat32(mul_r >> 16);
          state_r <= S_SFIN;
        end
        S_SFIN: begin
          sm_r    <= sat32(mul_r >> 16);
          state_r <= S_CHK;
        end

        // rejection checks and cell spacing
        S_CHK: begin
          if (sm_r == '0 || time_sigma_r == '0 || mass_high_r <= mass_low_r ||
              time_high_r <= time_low_r) begin
            status_r <= ST_SPLAT_REJ;
            state_r  <= S_DONE;
          end else begin
            div_req_r <= '{start: 1'b1, num: {32'b0, mass_high_r - mass_low_r},
                           den: 32'(GRID_COLS - 1), steps: DIV_STEPS_SPAN};
            ret_r     <= S_DM;
            state_r   <= S_DWAIT;
          end
        end
        S_DM: begin
          dm_r      <= div_quo[31:0];
          div_req_r <= '{start: 1'b1, num: {32'b0, time_high_r - time_low_r},
                         den: 32'(GRID_ROWS - 1), steps: DIV_STEPS_SPAN};
          ret_r     <= S_DT;
          state_r   <= S_DWAIT;
        end
        S_DT: begin
          dt_r    <= div_quo[31:0];
          state_r <= S_BOX;
        end
        S_BOX: begin
          if (dm_r == '0 || dt_r == '0 || outside) begin
            status_r <= ST_SPLAT_REJ;
            state_r  <= S_DONE;
          end else begin
            clip_sel_r <= 2'd0;
            state_r    <= S_CLIP;
          end
        end

        // box edges to grid indices
        S_CLIP, S_CLIPR: begin
          if (state_r == S_CLIPR || clip_below) begin
            case (clip_sel_r)
              2'd0:    i0_r <= clip_val[COL_W-1:0];
              2'd1:    i1_r <= clip_val[COL_W-1:0];
              2'd2:    j0_r <= clip_val[ROW_W-1:0];
              default: j1_r <= clip_val[ROW_W-1:0];
            endcase
            clip_sel_r <= clip_sel_r + 2'd1;
            state_r    <= (clip_sel_r == 2'd3) ? S_LOOP : S_CLIP;
          end else begin
            div_req_r <= '{start: 1'b1, num: {29'b0, clip_diff}, den: clip_dlt,
                           steps: DIV_STEPS_CLIP};
            ret_r     <= S_CLIPR;
            state_r   <= S_DWAIT;
          end
        end
        S_LOOP: begin
          j_r     <= j0_r;
          state_r <= S_ROW;
        end

        // per row: time coordinate and distance
        S_ROW: begin
          coord_r   <= 45'(time_low_r) + 45'(dt_r) * 45'(j_r);
          rowbase_r <= ADDR_W'(j_r * GRID_COLS);
          i_r       <= i0_r;
          state_r   <= S_ROWB;
        end
        S_ROWB: begin
          if (dist_big) begin
            b_r     <= DIST_MAX;
            state_r <= S_ROWSQ;
          end else begin
            div_req_r <= '{start: 1'b1, num: dist_num, den: time_sigma_r,
                           steps: DIV_STEPS_DIST};
            ret_r     <= S_ROWQ;
            state_r   <= S_DWAIT;
          end
        end
        S_ROWQ: begin
          b_r     <= div_quo[11:0];
          state_r <= S_ROWSQ;
        end
        S_ROWSQ: begin
          b2_r    <= b_r * b_r;
          state_r <= S_COL;
        end

        // per cell: mass coordinate and distance
        S_COL: begin
          coord_r <= 45'(mass_low_r) + 45'(dm_r) * 45'(i_r);
          state_r <= S_COLB;
        end
        S_COLB: begin
          if (dist_big) begin
            a_r     <= DIST_MAX;
            state_r <= S_Q;
          end else begin
            div_req_r <= '{start: 1'b1, num: dist_num, den: sm_r, steps: DIV_STEPS_DIST};
            ret_r     <= S_COLQ;
            state_r   <= S_DWAIT;
          end
        end
        S_COLQ: begin
          a_r     <= div_quo[11:0];
          state_r <= S_Q;
        end

        // weight 2^-t with t = q * log2(e) / 2
        S_Q: begin
          q_r     <= 25'(a_r * a_r) + {1'b0, b2_r};
          state_r <= S_T;
        end
        S_T: begin
          t_r     <= 25'(({16'b0, q_r} * {25'b0, HALF_LOG2E}) >> 16);
          state_r <= S_W1;
        end
        S_W1: begin
          base_r  <= pow2_neg({1'b0, t_r[15:12]});
          prod_r  <= 24'((pow2_neg({1'b0, t_r[15:12]}) -
                          pow2_neg(5'({1'b0, t_r[15:12]}) + 5'd1)) * {5'b0, t_r[11:0]});
          k_r     <= t_r[24:16];
          state_r <= S_W2;
        end
        S_W2: begin
          w_r        <= w_val;
          mem_rd_r   <= 1'b1;
          mem_addr_r <= rowbase_r + ADDR_W'(i_r);
          state_r    <= S_ADD;
        end

        // read-modify-write of the cell
        S_ADD: begin
          add_r   <= inten_r * w_r;
          state_r <= S_WR;
        end
        S_WR: begin
          mem_wr_r    <= 1'b1;
          mem_wdata_r <= cell_new;
          if (i_r == i1_r) begin
            if (j_r == j1_r) begin
              status_r <= ST_SPLAT_OK;
              state_r  <= S_DONE;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_ROW;
            end
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_COL;
          end
        end

        S_DWAIT: begin
          if (div_done) begin
            state_r <= ret_r;
          end
        end

        // hand the result to the output register
        S_DONE: begin
          if (can_load) begin
            out_valid_r           <= 1'b1;
            out_data_r.status     <= status_r;
            out_data_r.cell_value <= (kind_r == KIND_READ) ? cell_r : '0;
            state_r               <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE) || grid_busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd_r && mem_wr_r))
    else $error("grid read and write in the same cycle");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

  a_splat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_SPLAT_OK ||
                     out_data_r.status == ST_SPLAT_REJ)) |-> out_data_r.cell_value == '0)
    else $error("splat result carries a cell value");

  a_div_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DWAIT)
    else $error("divider finished while the sequencer was not waiting");

endmodule

FILE: rtl/core/gsplat_div.sv
// gsplat_div: shared restoring divider, one quotient bit per cycle.
// Depends on gsplat_pkg (div_req_t).
module gsplat_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gsplat_pkg::div_req_t req,
  output logic                done,
  output logic [63:0]         quo
);
  import gsplat_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [63:0] num_r;
  logic [63:0] quo_r;

  logic [32:0] rem2;
  logic        ge;
  logic [32:0] diff;

  // one restoring step
  always_comb begin
    rem2 = {rem_r, num_r[63]};
    ge   = rem2 >= {1'b0, den_r};
    diff = rem2 - {1'b0, den_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath; the remainder starts from the bits above the processed ones
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= 32'(req.num >> req.steps);
      num_r <= req.num << (7'd64 - req.steps);
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : rem2[31:0];
      num_r <= {num_r[62:0], 1'b0};
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/core/gsplat_isqrt.sv
// gsplat_isqrt: digit-by-digit integer square root of a 48-bit value,
// one result bit per cycle. Depends on gsplat_pkg.
module gsplat_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] value,
  output logic        done,
  output logic [23:0] root
);
  import gsplat_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [47:0] rem_r;
  logic [48:0] res_r;
  logic [47:0] bit_r;

  logic [48:0] trial;
  logic        take;

  always_comb begin
    trial = res_r + {1'b0, bit_r};
    take  = {1'b0, rem_r} >= trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == 48'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= value;
      res_r <= '0;
      bit_r <= 48'd1 << 46;
    end else if (busy_r) begin
      if (take) begin
        rem_r <= rem_r - trial[47:0];
        res_r <= (res_r >> 1) + {1'b0, bit_r};
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[23:0];

endmodule

FILE: rtl/core/gsplat_grid.sv
// gsplat_grid: single-port accumulator memory with registered read data and
// a zeroing sweep after reset. Depends on gsplat_pkg (CELL_W).
module gsplat_grid #(
  parameter  int DEPTH  = gsplat_pkg::DEF_GRID_COLS * gsplat_pkg::DEF_GRID_ROWS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             addr,
  input  logic [gsplat_pkg::CELL_W-1:0] wdata,
  output logic [gsplat_pkg::CELL_W-1:0] rdata,
  output logic                          busy
);
  import gsplat_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_r;
  logic              clr_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_r;

endmodule

FILE: tb/gaussian_grid_splat_core_test.sv
// gaussian_grid_splat_core_test: self-checking testbench for the splat core
// depends on gsplat_pkg and gaussian_grid_splat_core; keeps its own grid predictor
module gaussian_grid_splat_core_test;
  import gsplat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 256;
  localparam int ROWS = 256;
  localparam longint U32_ALL = 64'hFFFF_FFFF;
  localparam logic [63:0] CELL_FULL = 64'hFFFF_FFFF_FFFF;
  localparam int MAX_FOOTPRINT = 300;
  localparam int IDLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  gaussian_grid_splat_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  bit [47:0] acc_grid [0:COLS*ROWS-1];
  logic [63:0] m_low, m_high, t_low, t_high, sig_ref, m_ref, t_sig;
  logic [1:0] inst_sel;
  out_t expected_results [$];
  int hit_col [$];
  int hit_row [$];
  int error_count;
  int idle_cycles;
  bit quiet_source;
  bit quiet_sink;
  int sink_hold;

  // 2^(-n/16) in Q.16
  int unsigned exp2_frac [0:16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
    48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] clamp32(logic [63:0] v);
    return (v > U32_ALL) ? U32_ALL : v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // mass sigma scaled by instrument, zero when it cannot be formed
  function automatic logic [63:0] scaled_sigma(logic [63:0] pm);
    logic [63:0] r, s;
    if (inst_sel == INST_QUAD) return sig_ref;
    if (m_ref == 0) return 0;
    if (inst_sel == INST_TOF) return clamp32((sig_ref * pm) / m_ref);
    r = clamp32((pm << 16) / m_ref);
    if (inst_sel == INST_FTICR) s = clamp32((r * r) >> 16);
    else s = clamp32((r * int_sqrt(r << 16)) >> 16);
    return clamp32((sig_ref * s) >> 16);
  endfunction

  function automatic longint grid_index(longint v, longint lo, longint d, longint n);
    longint q;
    if (v < lo) return 0;
    q = (v - lo) / d;
    return (q > n - 1) ? n - 1 : q;
  endfunction

  function automatic logic [63:0] sigma_dist(longint d, logic [63:0] sg);
    logic [63:0] ad, a;
    ad = (d < 0) ? -d : d;
    a = (ad << 8) / sg;
    return (a > 4095) ? 64'd4095 : a;
  endfunction

  function automatic logic [63:0] kernel_weight(logic [63:0] q);
    logic [63:0] t, k, f, idx, r, v;
    t = (q * 47274) >> 16;
    k = t >> 16;
    f = t & 64'hFFFF;
    idx = f >> 12;
    r = f & 64'hFFF;
    if (k > 16) return 0;
    v = exp2_frac[idx] - (((exp2_frac[idx] - exp2_frac[idx + 1]) * r) >> 12);
    v = v >> k;
    return (v > 65535) ? 64'd65535 : v;
  endfunction

  // splat into the grid when apply is set; footprint gets the covered cell count
  function automatic logic [1:0] predict_splat(logic [63:0] pm, logic [63:0] pt,
      logic [63:0] inten, bit apply, output int footprint);
    logic [63:0] sm, dm, dt, b, a, add, sum;
    longint lo_m, hi_m, lo_t, hi_t, i0, i1, j0, j1;
    footprint = 0;
    sm = scaled_sigma(pm);
    if (sm == 0 || t_sig == 0) return ST_SPLAT_REJ;
    if (m_high <= m_low || t_high <= t_low) return ST_SPLAT_REJ;
    dm = (m_high - m_low) / (COLS - 1);
    dt = (t_high - t_low) / (ROWS - 1);
    if (dm == 0 || dt == 0) return ST_SPLAT_REJ;
    lo_m = longint'(pm) - 2 * longint'(sm);
    hi_m = longint'(pm) + 2 * longint'(sm);
    lo_t = longint'(pt) - 2 * longint'(t_sig);
    hi_t = longint'(pt) + 2 * longint'(t_sig);
    if (hi_t < longint'(t_low) || hi_m < longint'(m_low) ||
        lo_t > longint'(t_high) || lo_m > longint'(m_high)) return ST_SPLAT_REJ;
    i0 = grid_index(lo_m, m_low, dm, COLS);
    i1 = grid_index(hi_m, m_low, dm, COLS);
    j0 = grid_index(lo_t, t_low, dt, ROWS);
    j1 = grid_index(hi_t, t_low, dt, ROWS);
    footprint = int'((i1 - i0 + 1) * (j1 - j0 + 1));
    if (!apply) return ST_SPLAT_OK;
    for (longint j = j0; j <= j1; j++) begin
      b = sigma_dist(longint'(t_low + dt * j) - longint'(pt), t_sig);
      for (longint i = i0; i <= i1; i++) begin
        a = sigma_dist(longint'(m_low + dm * i) - longint'(pm), sm);
        add = inten * kernel_weight(a * a + b * b);
        sum = acc_grid[i + j * COLS] + add;
        acc_grid[i + j * COLS] = (sum > CELL_FULL) ? CELL_FULL[47:0] : sum[47:0];
      end
    end
    // remember the centre cell so reads can find it
    hit_col.push_back(int'((i0 + i1) / 2));
    hit_row.push_back(int'((j0 + j1) / 2));
    if (hit_col.size() > 64) begin
      void'(hit_col.pop_front());
      void'(hit_row.pop_front());
    end
    return ST_SPLAT_OK;
  endfunction

  function automatic out_t predict_result(in_t x);
    out_t r;
    int fp;
    r.cell_value = '0;
    if (x.kind == KIND_SPLAT) begin
      r.status = predict_splat(x.point_mass, x.point_time, x.intensity, 1'b1, fp);
    end else if (x.cell_col >= COLS || x.cell_row >= ROWS) begin
      r.status = ST_READ_OOR;
    end else begin
      r.status = ST_READ_OK;
      r.cell_value = acc_grid[x.cell_col + x.cell_row * COLS];
    end
    return r;
  endfunction

  // source: present one transaction, hold it until taken, then maybe a gap
  task automatic send_txn(in_t x);
    int gap, pick;
    in_valid <= 1'b1;
    in_data <= x;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    expected_results.push_back(predict_result(x));
    pick = $urandom_range(0, 99);
    if (quiet_source || pick < 65) gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MASS_LOW:   m_low = val;
      CFG_MASS_HIGH:  m_high = val;
      CFG_TIME_LOW:   t_low = val;
      CFG_TIME_HIGH:  t_high = val;
      CFG_SIGMA_REF:  sig_ref = val;
      CFG_MASS_REF:   m_ref = val;
      CFG_TIME_SIGMA: t_sig = val;
      default:        inst_sel = val[1:0];
    endcase
  endtask

  task automatic write_all(logic [31:0] ml, logic [31:0] mh, logic [31:0] tl,
      logic [31:0] th, logic [31:0] sr, logic [31:0] mr, logic [31:0] ts, logic [1:0] ins);
    write_reg(CFG_MASS_LOW, ml);
    write_reg(CFG_MASS_HIGH, mh);
    write_reg(CFG_TIME_LOW, tl);
    write_reg(CFG_TIME_HIGH, th);
    write_reg(CFG_SIGMA_REF, sr);
    write_reg(CFG_MASS_REF, mr);
    write_reg(CFG_TIME_SIGMA, ts);
    write_reg(CFG_INSTRUMENT, {30'd0, ins});
  endtask

  function automatic in_t make_splat(logic [31:0] pm, logic [31:0] pt, logic [31:0] it);
    in_t x;
    x.kind = KIND_SPLAT;
    x.point_mass = pm;
    x.point_time = pt;
    x.intensity = it;
    x.cell_col = $urandom;
    x.cell_row = $urandom;
    return x;
  endfunction

  function automatic in_t make_read(int c, int r);
    in_t x;
    x.kind = KIND_READ;
    x.point_mass = $urandom;
    x.point_time = $urandom;
    x.intensity = $urandom;
    x.cell_col = c;
    x.cell_row = r;
    return x;
  endfunction

  // random transaction; splats are mostly near the grid, footprint kept bounded
  function automatic in_t random_txn();
    in_t x;
    int fp, sel, k;
    logic [31:0] pm, pt, it;
    logic [1:0] st;
    if ($urandom_range(0, 99) < 40) begin
      if (hit_col.size() != 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, hit_col.size() - 1);
        return make_read(hit_col[k], hit_row[k]);
      end
      return make_read($urandom_range(0, 255), $urandom_range(0, 255));
    end
    for (int tries = 0; tries < 40; tries++) begin
      if ($urandom_range(0, 9) < 8 && m_high > m_low && t_high > t_low) begin
        pm = m_low + ({$urandom, $urandom} % (m_high - m_low + 1));
        pt = t_low + ({$urandom, $urandom} % (t_high - t_low + 1));
      end else begin
        pm = $urandom;
        pt = $urandom;
      end
      sel = $urandom_range(0, 9);
      it = (sel == 0) ? 32'hFFFF_FFFF : (sel < 4) ? $urandom_range(0, 1000) : $urandom;
      st = predict_splat(pm, pt, it, 1'b0, fp);
      if (fp <= MAX_FOOTPRINT) return make_splat(pm, pt, it);
    end
    return make_read($urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) send_txn(random_txn());
    drain();
  endtask

  // directed: extremes under the reset configuration
  task automatic test_reset_defaults();
    send_txn(make_splat(32'd13107200, 32'd32768000, 32'd1000));
    send_txn(make_read(hit_col[$], hit_row[$]));
    repeat (3) send_txn(make_splat(32'd13107200, 32'd32768000, 32'hFFFF_FFFF));
    send_txn(make_read(hit_col[$], hit_row[$]));
    send_txn(make_splat(32'd0, 32'd0, 32'd5000));
    send_txn(make_read(0, 0));
    send_txn(make_splat(32'd131072000, 32'd65536000, 32'd77));
    send_txn(make_read(255, 255));
    send_txn(make_splat(32'hFFFF_FFFF, 32'd100, 32'd9));
    send_txn(make_splat(32'd100, 32'hFFFF_FFFF, 32'd9));
    send_txn(make_splat(32'd5000000, 32'd1000000, 32'd0));
    send_txn(make_read(0, 255));
    send_txn(make_read(255, 0));
    drain();
  endtask

  task automatic test_instruments();
    for (int ins = 0; ins < 4; ins++) begin
      write_reg(CFG_INSTRUMENT, ins);
      send_txn(make_splat(32'd13107200, 32'd32768000, 32'd12345));
      send_txn(make_splat(32'd65536000, 32'd1000000, $urandom));
      run_random(15);
    end
  endtask

  // zero sigmas, zero reference mass, empty and too narrow spans
  task automatic test_special_configs();
    write_reg(CFG_TIME_SIGMA, 32'd0);
    run_random(5);
    write_reg(CFG_TIME_SIGMA, RST_TIME_SIGMA);
    write_reg(CFG_SIGMA_REF, 32'd0);
    run_random(5);
    write_reg(CFG_SIGMA_REF, RST_SIGMA_REF);
    write_reg(CFG_MASS_REF, 32'd0);
    for (int ins = 0; ins < 4; ins++) begin
      write_reg(CFG_INSTRUMENT, ins);
      send_txn(make_splat(32'd13107200, 32'd32768000, 32'd500));
      drain();
    end
    write_all(RST_MASS_LOW, RST_MASS_HIGH, RST_TIME_LOW, RST_TIME_HIGH,
              RST_SIGMA_REF, RST_MASS_REF, RST_TIME_SIGMA, INST_ORBITRAP);
    write_reg(CFG_MASS_HIGH, 32'd0);
    run_random(4);
    write_reg(CFG_MASS_HIGH, 32'd200);
    run_random(4);
    write_reg(CFG_MASS_HIGH, RST_MASS_HIGH);
    write_reg(CFG_TIME_LOW, 32'd1000);
    write_reg(CFG_TIME_HIGH, 32'd1000);
    run_random(4);
    write_reg(CFG_TIME_HIGH, 32'd1100);
    run_random(4);
  endtask

  // register extremes: full-width and top-end bounds
  task automatic test_extreme_bounds();
    write_all(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
              32'd65536, 32'hFFFF_FFFF, 32'd4000000, INST_QUAD);
    send_txn(make_splat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_txn(make_splat(32'd0, 32'd0, 32'hFFFF_FFFF));
    run_random(15);
    write_all(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, INST_TOF);
    run_random(15);
    write_all(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
              32'd1, 32'd1, 32'hFFFF_FFFF, INST_QUAD);
    send_txn(make_splat(32'h8000_0000, 32'h8000_0000, 32'd3));
    send_txn(make_read(128, 0));
    drain();
  endtask

  function automatic logic [31:0] pick_value(logic [31:0] base, logic [31:0] span);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'd0;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel == 2) return $urandom;
    return base + $urandom_range(0, span);
  endfunction

  task automatic test_random_configs();
    logic [31:0] ml, tl;
    for (int p = 0; p < 8; p++) begin
      ml = $urandom_range(0, 32'h4000_0000);
      tl = $urandom_range(0, 32'h4000_0000);
      quiet_source = (p == 3);
      quiet_sink = (p == 3);
      write_all(ml, ml + $urandom_range(32'h0010_0000, 32'h4000_0000),
                tl, tl + $urandom_range(32'h0010_0000, 32'h4000_0000),
                pick_value(32'd0, 32'h0010_0000), pick_value(32'd1, 32'h1000_0000),
                pick_value(32'd0, 32'h0080_0000), $urandom_range(0, 3));
      run_random(55);
    end
    quiet_source = 1'b0;
    quiet_sink = 1'b0;
  endtask

  // sink: random stall bursts, mostly short
  always @(posedge clk) begin
    if (quiet_sink) begin
      out_stall <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          out_stall <= 1'b1;
          sink_hold <= $urandom_range(0, 3);
        end
        3: begin
          out_stall <= 1'b1;
          sink_hold <= $urandom_range(10, 40);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // result check, sampled between edges
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%0h", $realtime,
                 out_data.status, out_data.cell_value);
        error_count++;
      end else begin
        if (out_data.status !== expected_results[0].status) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   expected_results[0].status, out_data.status);
          error_count++;
        end
        if (out_data.cell_value !== expected_results[0].cell_value) begin
          $display("%0t: cell_value expected %0h actual %0h", $realtime,
                   expected_results[0].cell_value, out_data.cell_value);
          error_count++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MASS_LOW;
    cfg_data <= '0;
    sink_hold = 0;
    quiet_source = 1'b0;
    quiet_sink = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    m_low = RST_MASS_LOW;
    m_high = RST_MASS_HIGH;
    t_low = RST_TIME_LOW;
    t_high = RST_TIME_HIGH;
    sig_ref = RST_SIGMA_REF;
    m_ref = RST_MASS_REF;
    t_sig = RST_TIME_SIGMA;
    inst_sel = INST_ORBITRAP;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_instruments();
    test_special_configs();
    test_extreme_bounds();
    test_random_configs();
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/gsplat_pkg.sv
rtl/core/gsplat_div.sv
rtl/core/gsplat_isqrt.sv
rtl/core/gsplat_grid.sv
rtl/core/gaussian_grid_splat_core.sv
tb/gaussian_grid_splat_core_test.sv
